// File: rtl/core/eul_pkg.sv
// Shared types, widths and constants of the epoch usage limiter.
// Used by the configuration block, the decision core, the top level and the checker.
// No dependencies.
package eul_pkg;

    // Field widths
    localparam int unsigned PAYLOAD_W  = 20;
    localparam int unsigned TICK_W     = 48;
    localparam int unsigned EPOCH_W    = 64;
    localparam int unsigned SEQ_W      = 64;
    localparam int unsigned BYTE_W     = 48;
    localparam int unsigned FRAME_W    = 32;
    localparam int unsigned STATUS_W   = 3;
    localparam int unsigned CFG_W      = 48;
    localparam int unsigned CFG_IDX_W  = 2;

    // Stream widths
    localparam int unsigned S_TDATA_W  = 200;
    localparam int unsigned S_TUSER_W  = 3;
    localparam int unsigned M_TDATA_W  = 136;

    // Largest plaintext payload of one frame
    localparam int unsigned MAX_PAYLOAD = 262144;

    // Default width of tick differences
    localparam int unsigned TIME_WIDTH_DEF = 48;

    // Register reset values and the thresholds derived from them
    localparam logic [BYTE_W-1:0]  BYTE_LIMIT_RST  = 48'd1073741824;
    localparam logic [FRAME_W-1:0] FRAME_LIMIT_RST = 32'd1048576;
    localparam logic [FRAME_W-1:0] FRAME_NEAR_RST  = 32'd917503;
    localparam logic [TICK_W-1:0]  TIME_LIMIT_RST  = 48'd1000000;
    localparam logic [TICK_W-1:0]  TIME_FIFTH_RST  = 48'd200000;
    localparam logic [TICK_W-1:0]  TIME_NEAR_RST   = 48'd800000;

    typedef enum logic [1:0] {
        OP_QUERY     = 2'd0,
        OP_SEND      = 2'd1,
        OP_RECV      = 2'd2,
        OP_NEW_EPOCH = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK              = 3'd0,
        ST_TOO_LARGE       = 3'd1,
        ST_REKEY_REQUIRED  = 3'd2,
        ST_SEQ_EXHAUSTED   = 3'd3,
        ST_UNEXPECTED      = 3'd4,
        ST_INBOUND_LIMIT   = 3'd5,
        ST_EPOCH_EXHAUSTED = 3'd6
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BYTE_LIMIT  = 2'd0,
        CFG_FRAME_LIMIT = 2'd1,
        CFG_TIME_LIMIT  = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        t_op                  operation;
        logic [PAYLOAD_W-1:0] payload_bytes;
        logic [TICK_W-1:0]    now_ticks;
        logic                 is_application;
        logic [EPOCH_W-1:0]   rx_epoch;
        logic [SEQ_W-1:0]     rx_sequence;
    } t_item;

    typedef struct packed {
        t_status            status;
        logic               rekey_needed;
        logic               rekey_soon;
        logic [EPOCH_W-1:0] frame_epoch;
        logic [SEQ_W-1:0]   frame_sequence;
    } t_result;

    // Limits and the near-limit thresholds handed to the core
    typedef struct packed {
        logic [BYTE_W-1:0]  byte_limit;
        logic [BYTE_W-1:0]  byte_near;
        logic [FRAME_W-1:0] frame_limit;
        logic [FRAME_W-1:0] frame_near;
        logic               frame_near_en;
        logic [TICK_W-1:0]  time_limit;
        logic [TICK_W-1:0]  time_near;
    } t_cfg;

endpackage

// File: rtl/core/eul_cfg.sv
// Limit registers and the near-limit thresholds derived from them.
// Depends on eul_pkg.
module eul_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [eul_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [eul_pkg::CFG_W-1:0]      i_cfg_wdata,
    output eul_pkg::t_cfg                  o_cfg
);
    import eul_pkg::*;

    // 2^24 and 2^12 each leave a remainder of one when divided by five
    localparam logic [21:0] DIV5_K24   = 22'd3355443;
    localparam logic [9:0]  DIV5_K12   = 10'd819;
    // Reciprocal of five scaled by 2^14, exact for operands below 2^14
    localparam logic [11:0] DIV5_RECIP = 12'd3277;
    localparam int unsigned DIV5_SHIFT = 14;

    // Divider contents for the reset time limit
    localparam logic [45:0] HI_PROD_RST  = 46'(TIME_LIMIT_RST[TICK_W-1:24]) * 46'(DIV5_K24);
    localparam logic [24:0] LO_SUM_RST   = 25'(TIME_LIMIT_RST[TICK_W-1:24]) +
                                           25'(TIME_LIMIT_RST[23:0]);
    localparam logic [22:0] MID_PROD_RST = 23'(LO_SUM_RST[24:12]) * 23'(DIV5_K12);
    localparam logic [13:0] MID_SUM_RST  = 14'(LO_SUM_RST[24:12]) + 14'(LO_SUM_RST[11:0]);

    logic [BYTE_W-1:0]  r_byte_limit;
    logic [FRAME_W-1:0] r_frame_limit;
    logic [FRAME_W-1:0] r_frame_near;
    logic               r_frame_near_en;
    logic [TICK_W-1:0]  r_time_limit;
    logic [TICK_W-1:0]  r_time_fifth;
    logic [TICK_W-1:0]  r_time_near;

    logic [45:0]        r_hi_prod;
    logic [24:0]        r_lo_sum;
    logic [22:0]        r_mid_prod;
    logic [13:0]        r_mid_sum;

    logic [FRAME_W-1:0] frame_thr;
    logic [25:0]        tail_prod;
    logic [11:0]        tail_quot;

    // Take register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_limit  <= BYTE_LIMIT_RST;
            r_frame_limit <= FRAME_LIMIT_RST;
            r_time_limit  <= TIME_LIMIT_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_BYTE_LIMIT: begin
                    r_byte_limit <= i_cfg_wdata[BYTE_W-1:0];
                end
                CFG_FRAME_LIMIT: begin
                    r_frame_limit <= i_cfg_wdata[FRAME_W-1:0];
                end
                CFG_TIME_LIMIT: begin
                    r_time_limit <= i_cfg_wdata[TICK_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Quotient of the last small sum by five
    assign tail_prod = 26'(r_mid_sum) * 26'(DIV5_RECIP);
    assign tail_quot = tail_prod[DIV5_SHIFT +: 12];

    // Divide the time limit by five in three steps: split at bit 24, then at bit 12
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hi_prod    <= HI_PROD_RST;
            r_lo_sum     <= LO_SUM_RST;
            r_mid_prod   <= MID_PROD_RST;
            r_mid_sum    <= MID_SUM_RST;
            r_time_fifth <= TIME_FIFTH_RST;
        end else begin
            r_hi_prod    <= 46'(r_time_limit[TICK_W-1:24]) * 46'(DIV5_K24);
            r_lo_sum     <= 25'(r_time_limit[TICK_W-1:24]) + 25'(r_time_limit[23:0]);
            r_mid_prod   <= 23'(r_lo_sum[24:12]) * 23'(DIV5_K12);
            r_mid_sum    <= 14'(r_lo_sum[24:12]) + 14'(r_lo_sum[11:0]);
            r_time_fifth <= 48'(r_hi_prod) + 48'(r_mid_prod) + 48'(tail_quot);
        end
    end

    // Seven eighths of the frame limit
    assign frame_thr = r_frame_limit - (r_frame_limit >> 3);

    // Register the near-limit thresholds behind the limits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_near    <= FRAME_NEAR_RST;
            r_frame_near_en <= 1'b1;
            r_time_near     <= TIME_NEAR_RST;
        end else begin
            r_frame_near    <= frame_thr - 32'd1;
            r_frame_near_en <= (frame_thr != '0);
            r_time_near     <= r_time_limit - r_time_fifth;
        end
    end

    always_comb begin
        o_cfg.byte_limit    = r_byte_limit;
        o_cfg.byte_near     = r_byte_limit >> 2;
        o_cfg.frame_limit   = r_frame_limit;
        o_cfg.frame_near    = r_frame_near;
        o_cfg.frame_near_en = r_frame_near_en;
        o_cfg.time_limit    = r_time_limit;
        o_cfg.time_near     = r_time_near;
    end

endmodule

// File: rtl/core/eul_core.sv
// Epoch state and the combinational decision for one item.
// Depends on eul_pkg.
module eul_core #(
    parameter int unsigned TIME_WIDTH = eul_pkg::TIME_WIDTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  eul_pkg::t_item    i_item,
    input  eul_pkg::t_cfg     i_cfg,
    output eul_pkg::t_result  o_result
);
    import eul_pkg::*;

    localparam int unsigned EXT_W = (TIME_WIDTH > TICK_W) ? TIME_WIDTH : TICK_W;
    localparam logic [EXT_W-1:0] TIME_MASK = {EXT_W{1'b1}} >> (EXT_W - TIME_WIDTH);

    logic [EPOCH_W-1:0] r_epoch_number;
    logic [SEQ_W-1:0]   r_next_sequence;
    logic [BYTE_W-1:0]  r_byte_count;
    logic [FRAME_W-1:0] r_frame_count;
    logic               r_active;
    logic [TICK_W-1:0]  r_first_use;

    logic [EPOCH_W-1:0] n_epoch_number;
    logic [SEQ_W-1:0]   n_next_sequence;
    logic [BYTE_W-1:0]  n_byte_count;
    logic [FRAME_W-1:0] n_frame_count;
    logic               n_active;
    logic [TICK_W-1:0]  n_first_use;

    logic [EXT_W-1:0]  elapsed;
    logic [BYTE_W:0]   byte_sum;
    logic              time_out;
    logic              time_near;
    logic              bytes_out;
    logic              frames_out;
    logic              usage_out;
    logic              rekey_req;
    logic              bytes_near;
    logic              frames_near;
    logic              too_large;
    logic              seq_full;
    logic              epoch_full;
    logic              id_mismatch;
    logic              take_seq;
    logic              do_account;
    logic              new_epoch;

    // Usage and time tests
    assign elapsed     = (EXT_W'(i_item.now_ticks) - EXT_W'(r_first_use)) & TIME_MASK;
    assign time_out    = elapsed >= EXT_W'(i_cfg.time_limit);
    assign time_near   = r_active && (elapsed >= EXT_W'(i_cfg.time_near));
    assign byte_sum    = {1'b0, r_byte_count} + (BYTE_W + 1)'(i_item.payload_bytes);
    assign bytes_out   = byte_sum > {1'b0, i_cfg.byte_limit};
    assign bytes_near  = byte_sum >= {1'b0, i_cfg.byte_near};
    assign frames_out  = r_frame_count >= i_cfg.frame_limit;
    assign frames_near = i_cfg.frame_near_en && (r_frame_count >= i_cfg.frame_near);
    assign usage_out   = bytes_out || frames_out;
    assign rekey_req   = r_active && (usage_out || time_out);
    assign too_large   = i_item.payload_bytes > PAYLOAD_W'(MAX_PAYLOAD);
    assign seq_full    = &r_next_sequence;
    assign epoch_full  = &r_epoch_number;
    assign id_mismatch = (i_item.rx_epoch != r_epoch_number) ||
                         (i_item.rx_sequence != r_next_sequence);

    // Decide the status and what the item changes
    always_comb begin
        o_result.status         = ST_OK;
        o_result.rekey_needed   = 1'b0;
        o_result.rekey_soon     = 1'b0;
        o_result.frame_epoch    = r_epoch_number;
        o_result.frame_sequence = r_next_sequence;
        take_seq   = 1'b0;
        do_account = 1'b0;
        new_epoch  = 1'b0;
        case (i_item.operation)
            OP_QUERY: begin
                if (too_large) begin
                    o_result.status = ST_TOO_LARGE;
                end else begin
                    o_result.rekey_needed = rekey_req;
                    o_result.rekey_soon   = rekey_req || bytes_near || frames_near ||
                                            time_near;
                end
            end
            OP_SEND: begin
                if (seq_full) begin
                    o_result.status = ST_SEQ_EXHAUSTED;
                end else if (i_item.is_application && too_large) begin
                    o_result.status = ST_TOO_LARGE;
                end else if (i_item.is_application && rekey_req) begin
                    o_result.status = ST_REKEY_REQUIRED;
                end else begin
                    take_seq   = 1'b1;
                    do_account = i_item.is_application;
                end
            end
            OP_RECV: begin
                if (id_mismatch) begin
                    o_result.status = ST_UNEXPECTED;
                end else if (seq_full) begin
                    o_result.status = ST_SEQ_EXHAUSTED;
                end else if (too_large) begin
                    o_result.status = ST_TOO_LARGE;
                end else if (i_item.is_application && r_active && usage_out) begin
                    o_result.status = ST_INBOUND_LIMIT;
                end else begin
                    take_seq   = 1'b1;
                    do_account = i_item.is_application;
                end
            end
            OP_NEW_EPOCH: begin
                if (epoch_full) begin
                    o_result.status = ST_EPOCH_EXHAUSTED;
                end else begin
                    new_epoch = 1'b1;
                    o_result.frame_epoch    = r_epoch_number + 64'd1;
                    o_result.frame_sequence = '0;
                end
            end
            default: begin
            end
        endcase
    end

    // Next epoch state
    always_comb begin
        n_epoch_number  = r_epoch_number;
        n_next_sequence = r_next_sequence;
        n_byte_count    = r_byte_count;
        n_frame_count   = r_frame_count;
        n_active        = r_active;
        n_first_use     = r_first_use;
        if (take_seq) begin
            n_next_sequence = r_next_sequence + 64'd1;
        end
        if (do_account) begin
            if (!r_active) begin
                n_active    = 1'b1;
                n_first_use = i_item.now_ticks;
            end
            n_byte_count  = byte_sum[BYTE_W] ? {BYTE_W{1'b1}} : byte_sum[BYTE_W-1:0];
            n_frame_count = (&r_frame_count) ? r_frame_count : r_frame_count + 32'd1;
        end
        if (new_epoch) begin
            n_epoch_number  = o_result.frame_epoch;
            n_next_sequence = '0;
            n_byte_count    = '0;
            n_frame_count   = '0;
            n_active        = 1'b0;
            n_first_use     = '0;
        end
    end

    // Commit when the item moves to the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_epoch_number  <= '0;
            r_next_sequence <= '0;
            r_byte_count    <= '0;
            r_frame_count   <= '0;
            r_active        <= 1'b0;
            r_first_use     <= '0;
        end else if (i_fire) begin
            r_epoch_number  <= n_epoch_number;
            r_next_sequence <= n_next_sequence;
            r_byte_count    <= n_byte_count;
            r_frame_count   <= n_frame_count;
            r_active        <= n_active;
            r_first_use     <= n_first_use;
        end
    end

endmodule

// File: rtl/core/epoch_usage_limiter_unit.sv
// Top level of the epoch usage limiter: input register, decision core, result register.
// Depends on eul_pkg, eul_cfg and eul_core.
//
//   channel | direction | transfer
//   --------+-----------+-------------------------------------------------
//   s axis  | in        | one item per i_s_tvalid & o_s_tready
//   m axis  | out       | one result per o_m_tvalid & i_m_tready
//   cfg     | in        | one register write per i_cfg_we, no wait
//
// The decision core works on the input register; the result register takes its output
// when free or being drained. One item per cycle is sustained while the master side does
// not stall; the epoch state updates as the item enters the result register. Reset is
// synchronous, empties both registers and restores the default limits. A stalled result
// holds the input register, which then stalls the slave side. A limit write reaches the
// frame threshold in the next cycle and the time threshold through the divider steps.
module epoch_usage_limiter_unit #(
    parameter int unsigned TIME_WIDTH = eul_pkg::TIME_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Slave side
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    // payload_bytes[19:0], now_ticks[67:20], rx_epoch[131:68], rx_sequence[195:132]
    input  logic [eul_pkg::S_TDATA_W-1:0] i_s_tdata,
    // operation[1:0], is_application[2]
    input  logic [eul_pkg::S_TUSER_W-1:0] i_s_tuser,
    // Master side
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // status[2:0], rekey_needed[3], rekey_soon[4], frame_epoch[68:5],
    // frame_sequence[132:69]
    output logic [eul_pkg::M_TDATA_W-1:0] o_m_tdata,
    // Configuration write port
    input  logic                          i_cfg_we,
    input  logic [eul_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [eul_pkg::CFG_W-1:0]     i_cfg_wdata
);
    import eul_pkg::*;

    logic    r_in_valid;
    t_item   r_in_item;
    logic    r_out_valid;
    t_result r_out_result;

    t_item   s_item;
    t_cfg    cfg;
    t_result result;
    logic    advance;
    logic    s_accept;

    // Unpack the slave item
    always_comb begin
        s_item.operation      = t_op'(i_s_tuser[1:0]);
        s_item.is_application = i_s_tuser[2];
        s_item.payload_bytes  = i_s_tdata[19:0];
        s_item.now_ticks      = i_s_tdata[67:20];
        s_item.rx_epoch       = i_s_tdata[131:68];
        s_item.rx_sequence    = i_s_tdata[195:132];
    end

    // Move an item forward when the result register is free or being drained
    assign advance    = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || advance;
    assign s_accept   = i_s_tvalid && o_s_tready;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_in_item <= s_item;
        end
    end

    eul_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    eul_core #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (advance),
        .i_item   (r_in_item),
        .i_cfg    (cfg),
        .o_result (result)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_result <= result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {3'b000,
                         r_out_result.frame_sequence,
                         r_out_result.frame_epoch,
                         r_out_result.rekey_soon,
                         r_out_result.rekey_needed,
                         r_out_result.status};

endmodule

// File: rtl/core/eul_checker.sv
// Port-level checks of the epoch usage limiter, bound to its top level.
// Depends on eul_pkg and epoch_usage_limiter_unit.
module eul_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          o_s_tready,
    input  logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    input  logic [eul_pkg::M_TDATA_W-1:0] o_m_tdata
);
    import eul_pkg::*;

    // A result waiting at the master side holds its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("stalled result changed");

    // Slave side stalls only behind a stalled result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> o_m_tvalid && !i_m_tready)
        else $error("slave side stalled without back-pressure");

    // Failed items carry no rekey flags
    a_err_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tdata[2:0] != ST_OK) |-> !o_m_tdata[3] && !o_m_tdata[4])
        else $error("rekey flag set on an error result");

    // A required rekey is always also reported as soon
    a_needed_soon: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[3] |-> o_m_tdata[4])
        else $error("rekey needed without rekey soon");

    // Reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

endmodule

bind epoch_usage_limiter_unit eul_checker u_eul_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

// File: tb/sv/tb_epoch_usage_limiter_unit.sv
// Self-checking testbench of the epoch usage limiter: stream driver, result monitor and
// a cycle-free predictor of the epoch state, over several limit settings and idle patterns.
// Depends on eul_pkg and epoch_usage_limiter_unit.
module tb_epoch_usage_limiter_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import eul_pkg::*;

    // One pending item; aimed fields are offsets from the state seen when it is presented
    typedef struct {
        t_item item;
        bit    aim_rx;   // rx_epoch / rx_sequence are offsets from the expected pair
        bit    aim_now;  // now_ticks is an offset from the first-use time
    } t_stim;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 s_tvalid    = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata     = '0;
    logic [S_TUSER_W-1:0] s_tuser     = '0;
    logic                 m_tvalid;
    logic                 m_tready    = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index   = CFG_BYTE_LIMIT;
    logic [CFG_W-1:0]     cfg_wdata   = '0;

    // Limits as the block holds them
    bit [47:0] lim_bytes  = BYTE_LIMIT_RST;
    bit [31:0] lim_frames = FRAME_LIMIT_RST;
    bit [47:0] lim_ticks  = TIME_LIMIT_RST;

    // Predicted epoch state
    bit [63:0] cur_epoch   = '0;
    bit [63:0] cur_seq     = '0;
    bit [47:0] used_bytes  = '0;
    bit [31:0] used_frames = '0;
    bit        epoch_live  = 1'b0;
    bit [47:0] live_since  = '0;

    t_stim   stim_q[$];
    t_result verdicts_due[$];
    t_item   bus_item;

    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned fail_count     = 0;
    int unsigned results_checked = 0;
    int unsigned settings_run   = 1;
    int unsigned status_seen[0:7];

    epoch_usage_limiter_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_wdata (cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    // ---------------------------------------------------------------- predictor

    function automatic bit [47:0] ticks_since(bit [47:0] now);
        return now - live_since;
    endfunction

    function automatic bit over_budget(bit [19:0] pay);
        return used_bytes > lim_bytes || 48'(pay) > (lim_bytes - used_bytes) ||
            used_frames >= lim_frames;
    endfunction

    function automatic bit rekey_due(bit [19:0] pay, bit [47:0] now);
        return epoch_live && (over_budget(pay) || ticks_since(now) >= lim_ticks);
    endfunction

    // Take the next sequence number and account an application frame
    function automatic void advance_frame(bit app, bit [19:0] pay, bit [47:0] now);
        bit [48:0] sum;
        cur_seq = cur_seq + 64'd1;
        if (app) begin
            if (!epoch_live) begin
                epoch_live = 1'b1;
                live_since = now;
            end
            sum = 49'(used_bytes) + 49'(pay);
            used_bytes = sum[48] ? 48'hFFFF_FFFF_FFFF : sum[47:0];
            if (used_frames != 32'hFFFF_FFFF)
                used_frames = used_frames + 32'd1;
        end
    endfunction

    // Decide one item against the epoch state and update it
    function automatic t_result decide_frame(t_item it);
        t_result   r;
        bit [47:0] bthr;
        bit [31:0] mthr;
        bit [47:0] tthr;
        bit        req;
        r.status         = ST_OK;
        r.rekey_needed   = 1'b0;
        r.rekey_soon     = 1'b0;
        r.frame_epoch    = cur_epoch;
        r.frame_sequence = cur_seq;
        case (it.operation)
            OP_QUERY: begin
                if (it.payload_bytes > MAX_PAYLOAD) begin
                    r.status = ST_TOO_LARGE;
                end else begin
                    bthr = lim_bytes / 4;
                    mthr = lim_frames - lim_frames / 8;
                    tthr = lim_ticks - lim_ticks / 5;
                    req  = rekey_due(it.payload_bytes, it.now_ticks);
                    r.rekey_needed = req;
                    r.rekey_soon = req || used_bytes >= bthr ||
                        48'(it.payload_bytes) >= bthr - used_bytes ||
                        (mthr != 0 && used_frames >= mthr - 32'd1) ||
                        (epoch_live && ticks_since(it.now_ticks) >= tthr);
                end
            end
            OP_SEND: begin
                if (cur_seq == '1)
                    r.status = ST_SEQ_EXHAUSTED;
                else if (it.is_application && it.payload_bytes > MAX_PAYLOAD)
                    r.status = ST_TOO_LARGE;
                else if (it.is_application && rekey_due(it.payload_bytes, it.now_ticks))
                    r.status = ST_REKEY_REQUIRED;
                else
                    advance_frame(it.is_application, it.payload_bytes, it.now_ticks);
            end
            OP_RECV: begin
                if (it.rx_epoch != cur_epoch || it.rx_sequence != cur_seq)
                    r.status = ST_UNEXPECTED;
                else if (cur_seq == '1)
                    r.status = ST_SEQ_EXHAUSTED;
                else if (it.payload_bytes > MAX_PAYLOAD)
                    r.status = ST_TOO_LARGE;
                else if (it.is_application && epoch_live && over_budget(it.payload_bytes))
                    r.status = ST_INBOUND_LIMIT;
                else
                    advance_frame(it.is_application, it.payload_bytes, it.now_ticks);
            end
            default: begin
                if (cur_epoch == '1) begin
                    r.status = ST_EPOCH_EXHAUSTED;
                end else begin
                    cur_epoch   = cur_epoch + 64'd1;
                    cur_seq     = '0;
                    used_bytes  = '0;
                    used_frames = '0;
                    epoch_live  = 1'b0;
                    live_since  = '0;
                    r.frame_epoch    = cur_epoch;
                    r.frame_sequence = '0;
                end
            end
        endcase
        return r;
    endfunction

    // ---------------------------------------------------------------- driver

    always @(posedge i_clk) begin : drive_items
        t_stim nxt;
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            // Predict the item taken at this edge before the next one is resolved
            if (s_tvalid && s_tready)
                verdicts_due.insert(verdicts_due.size(), decide_frame(bus_item));
            if (!s_tvalid || s_tready) begin
                if (stim_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    nxt = stim_q.pop_front();
                    if (nxt.aim_rx) begin
                        nxt.item.rx_epoch    = cur_epoch + nxt.item.rx_epoch;
                        nxt.item.rx_sequence = cur_seq + nxt.item.rx_sequence;
                    end
                    if (nxt.aim_now)
                        nxt.item.now_ticks = live_since + nxt.item.now_ticks;
                    bus_item <= nxt.item;
                    s_tvalid <= 1'b1;
                    s_tdata  <= {4'b0, nxt.item.rx_sequence, nxt.item.rx_epoch,
                                 nxt.item.now_ticks, nxt.item.payload_bytes};
                    s_tuser  <= {nxt.item.is_application, nxt.item.operation};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------- monitor

    task automatic note_field(string name, bit [63:0] want, logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin : watch_results
        t_result want;
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (verdicts_due.size() == 0) begin
                    $error("result %0h arrived with no item outstanding", m_tdata);
                    fail_count++;
                end else begin
                    want = verdicts_due.pop_front();
                    note_field("status", 64'(want.status), 64'(m_tdata[2:0]));
                    note_field("rekey_needed", 64'(want.rekey_needed), 64'(m_tdata[3]));
                    note_field("rekey_soon", 64'(want.rekey_soon), 64'(m_tdata[4]));
                    note_field("frame_epoch", want.frame_epoch, m_tdata[68:5]);
                    note_field("frame_sequence", want.frame_sequence, m_tdata[132:69]);
                    status_seen[int'(want.status)]++;
                    results_checked++;
                end
            end
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // ---------------------------------------------------------------- stimulus

    function automatic bit [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic void push_stim(t_op op, bit [19:0] pay, bit [47:0] now, bit app,
                                      bit [63:0] rxe, bit [63:0] rxs,
                                      bit aim_rx, bit aim_now);
        t_stim s;
        s.item.operation      = op;
        s.item.payload_bytes  = pay;
        s.item.now_ticks      = now;
        s.item.is_application = app;
        s.item.rx_epoch       = rxe;
        s.item.rx_sequence    = rxs;
        s.aim_rx              = aim_rx;
        s.aim_now             = aim_now;
        stim_q.insert(stim_q.size(), s);
    endfunction

    // Mostly well-formed traffic against the current limits, some noise
    function automatic void push_random_frame();
        t_op       op;
        bit [19:0] pay;
        bit [47:0] cap;
        bit [47:0] now;
        bit [63:0] rxe;
        bit [63:0] rxs;
        int unsigned pick;
        if ($urandom_range(99) < 12) begin
            // Noise: every field random, nothing aimed
            push_stim(t_op'($urandom_range(3)), 20'($urandom), 48'(rand64()),
                      1'($urandom), rand64(), rand64(), 1'b0, 1'b0);
        end else begin
            pick = $urandom_range(99);
            op = pick < 20 ? OP_QUERY : pick < 55 ? OP_SEND : pick < 92 ? OP_RECV
                : OP_NEW_EPOCH;
            cap = lim_bytes / 3;
            if (cap > MAX_PAYLOAD)
                cap = MAX_PAYLOAD;
            case ($urandom_range(11))
                0:       pay = '0;
                1:       pay = 20'(MAX_PAYLOAD);
                2:       pay = 20'(MAX_PAYLOAD + 1);
                3:       pay = '1;
                4:       pay = 20'($urandom);
                5:       pay = 20'(cap);
                default: pay = 20'($urandom_range(cap[31:0]));
            endcase
            case ($urandom_range(7))
                0:       now = '0;
                1:       now = lim_ticks - 48'd1;
                2:       now = lim_ticks;
                3:       now = lim_ticks - lim_ticks / 5 - 48'd1;
                4:       now = lim_ticks - lim_ticks / 5;
                5:       now = 48'(rand64());
                default: now = 48'(rand64() % (64'(lim_ticks) + 64'd1));
            endcase
            // Mostly the expected epoch and sequence, sometimes one off
            rxe = '0;
            rxs = '0;
            if ($urandom_range(99) < 15) begin
                case ($urandom_range(3))
                    0: rxe = 64'd1;
                    1: rxe = '1;
                    2: rxs = 64'd1;
                    default: rxs = '1;
                endcase
            end
            push_stim(op, pay, now, $urandom_range(99) < 80, rxe, rxs, 1'b1, 1'b1);
        end
    endfunction

    task automatic wait_drained();
        while (stim_q.size() != 0 || s_tvalid || verdicts_due.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_limit(t_cfg_idx idx, bit [47:0] value);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        case (idx)
            CFG_BYTE_LIMIT:  lim_bytes  = value;
            CFG_FRAME_LIMIT: lim_frames = value[31:0];
            default:         lim_ticks  = value;
        endcase
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_limits(bit [47:0] bytes, bit [31:0] frames, bit [47:0] ticks);
        write_limit(CFG_BYTE_LIMIT, bytes);
        write_limit(CFG_FRAME_LIMIT, 48'(frames));
        write_limit(CFG_TIME_LIMIT, ticks);
        // Let the thresholds settle after the limits
        repeat (6) @(posedge i_clk);
        settings_run++;
    endtask

    initial begin : run_test
        int unsigned phase;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // Directed: reset limits, field extremes, every operation, ok/too-large/rekey/unexpected
        push_stim(OP_QUERY, '0, '0, 1'b1, '0, '0, 1'b0, 1'b0);
        push_stim(OP_QUERY, 20'(MAX_PAYLOAD + 1), '0, 1'b1, '0, '0, 1'b0, 1'b0);
        push_stim(OP_QUERY, '1, '0, 1'b1, '0, '0, 1'b0, 1'b0);
        // non-application send skips the size check
        push_stim(OP_SEND, '1, '0, 1'b0, '0, '0, 1'b0, 1'b0);
        push_stim(OP_SEND, 20'(MAX_PAYLOAD + 1), '0, 1'b1, '0, '0, 1'b0, 1'b0);
        // first use at the top of the tick range, later times wrap
        push_stim(OP_SEND, 20'(MAX_PAYLOAD), '1, 1'b1, '0, '0, 1'b0, 1'b0);
        push_stim(OP_QUERY, '0, 48'd5, 1'b1, '0, '0, 1'b0, 1'b1);
        push_stim(OP_RECV, 20'd100, 48'd10, 1'b1, '0, '0, 1'b1, 1'b1);
        push_stim(OP_RECV, 20'd100, 48'd10, 1'b1, 64'd1, '0, 1'b1, 1'b1);
        push_stim(OP_RECV, 20'd100, 48'd10, 1'b1, '0, '1, 1'b1, 1'b1);
        push_stim(OP_RECV, 20'(MAX_PAYLOAD + 1), 48'd10, 1'b1, '0, '0, 1'b1, 1'b1);
        push_stim(OP_RECV, '1, 48'd10, 1'b0, '0, '0, 1'b1, 1'b1);
        push_stim(OP_RECV, 20'd7, 48'd11, 1'b0, '0, '0, 1'b1, 1'b1);
        // time limit: send refused, query flags, receive not time checked
        push_stim(OP_SEND, 20'd1, 48'(TIME_LIMIT_RST), 1'b1, '0, '0, 1'b0, 1'b1);
        push_stim(OP_QUERY, '0, 48'(TIME_LIMIT_RST) - 48'd1, 1'b1, '0, '0, 1'b0, 1'b1);
        push_stim(OP_QUERY, '0, 48'(TIME_LIMIT_RST), 1'b1, '0, '0, 1'b0, 1'b1);
        push_stim(OP_RECV, 20'd1, 48'(TIME_LIMIT_RST) * 2, 1'b1, '0, '0, 1'b1, 1'b1);
        push_stim(OP_NEW_EPOCH, '0, '0, 1'b0, '0, '0, 1'b0, 1'b0);
        push_stim(OP_NEW_EPOCH, '1, '1, 1'b1, '1, '1, 1'b0, 1'b0);
        push_stim(OP_QUERY, '0, '1, 1'b1, '1, '1, 1'b0, 1'b0);
        wait_drained();

        // Directed: tight byte and frame budgets
        set_limits(48'd1000, 32'd3, 48'd100);
        push_stim(OP_SEND, 20'd600, 48'd0, 1'b1, '0, '0, 1'b0, 1'b1);
        push_stim(OP_QUERY, '0, 48'd1, 1'b1, '0, '0, 1'b0, 1'b1);
        push_stim(OP_SEND, 20'd600, 48'd2, 1'b1, '0, '0, 1'b0, 1'b1);
        push_stim(OP_RECV, 20'd500, 48'd3, 1'b1, '0, '0, 1'b1, 1'b1);
        push_stim(OP_RECV, 20'd400, 48'd4, 1'b1, '0, '0, 1'b1, 1'b1);
        push_stim(OP_SEND, 20'd0, 48'd5, 1'b1, '0, '0, 1'b0, 1'b1);
        push_stim(OP_QUERY, '0, 48'd6, 1'b1, '0, '0, 1'b0, 1'b1);
        push_stim(OP_NEW_EPOCH, '0, '0, 1'b0, '0, '0, 1'b0, 1'b0);
        wait_drained();

        // Random phases: each pairs a limit setting with an idle pattern
        for (phase = 0; phase < 8; phase++) begin
            case (phase)
                1:  set_limits(48'd1, 32'd1, 48'd1);
                2:  set_limits('1, '1, '1);
                4:  set_limits(BYTE_LIMIT_RST, FRAME_LIMIT_RST, TIME_LIMIT_RST);
                6:  set_limits('1, 32'($urandom_range(2, 20)), 48'($urandom_range(20, 400)));
                default:
                    set_limits(48'($urandom_range(2000, 400000)), 32'($urandom_range(4, 40)),
                               48'($urandom_range(50, 5000)));
            endcase
            case (phase % 4)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 84;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 84;
                end
                default: begin
                    send_idle_pct  = 12;
                    recv_stall_pct = 12;
                end
            endcase
            repeat (107) push_random_frame();
            wait_drained();
        end

        repeat (10) @(posedge i_clk);
        $display("Checked %0d results over %0d limit settings and four idle patterns.",
                 results_checked, settings_run);
        $display("Statuses: ok %0d, too large %0d, rekey %0d, unexpected %0d, inbound %0d",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[4],
                 status_seen[5]);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Hard stop well past the slowest correct run
    initial begin : watchdog
        #5_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
